>>> rtl/core/pcsp_pkg.sv
`default_nettype none

package pcsp_pkg;

    localparam int DEF_MAX_NODES = 32;
    localparam int COST_W        = 37;

    localparam logic [5:0] NODE_COUNT_RESET = 6'd32;
    localparam logic [7:0] LETTER_FIRST     = 8'd65;
    localparam logic [4:0] LETTER_LAST      = 5'd25;

    typedef struct packed {
        logic [7:0]  edge_colour;
        logic [31:0] edge_weight;
        logic        last_entry;
    } in_item_t;

    typedef struct packed {
        logic              path_found;
        logic [4:0]        best_letter;
        logic [COST_W-1:0] best_cost;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       st_wr;
        logic       init_rd;
        logic       diag;
        logic       ik_load;
        logic       stream_rd;
        logic       res_cmp;
        logic       best_clear;
        logic       out_load;
        logic [4:0] letter;
    } pcsp_cmd_t;

    typedef struct packed {
        logic ik_inf;
        logic out_full;
    } pcsp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/pcsp_datapath.sv
`default_nettype none

module pcsp_datapath #(
    parameter int MAX_NODES = pcsp_pkg::DEF_MAX_NODES
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  pcsp_pkg::pcsp_cmd_t                      cmd,
    input  wire [$clog2(MAX_NODES*MAX_NODES)-1:0]    st_addr,
    input  wire [$clog2(MAX_NODES*MAX_NODES)-1:0]    addr_a,
    input  wire [$clog2(MAX_NODES*MAX_NODES)-1:0]    addr_b,
    input  pcsp_pkg::in_item_t                       in_data,
    output pcsp_pkg::pcsp_stat_t                     stat,
    output logic                                     out_valid,
    input  wire                                      out_ready,
    output pcsp_pkg::out_item_t                      out_data
);
    import pcsp_pkg::*;

    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_NODES);
    // Top bit marks an unreachable pair; finite costs stay below it.
    localparam int DIST_W = 32 + IDX_W + 1;
    localparam logic [DIST_W-1:0] DIST_INF = {1'b1, {(DIST_W-1){1'b0}}};

    logic [7:0]        colour_mem [DEPTH];
    logic [31:0]       weight_mem [DEPTH];
    logic [DIST_W-1:0] dist_mem   [DEPTH];

    logic [7:0]        colour_rd_reg;
    logic [31:0]       weight_rd_reg;
    logic [DIST_W-1:0] dist_a_reg;
    logic [DIST_W-1:0] dist_b_reg;
    logic [DIST_W-1:0] ik_reg;
    logic [ADDR_W-1:0] waddr_reg;
    logic              diag_reg;
    logic              init_v_reg;
    logic              stream_v_reg;
    logic [DIST_W-1:0] best_reg;
    logic [DIST_W-1:0] best_next;
    logic [4:0]        best_idx_reg;
    logic [4:0]        best_idx_next;
    logic              out_valid_reg;
    out_item_t         out_data_reg;
    out_item_t         out_data_next;

    logic [DIST_W-1:0] sum;
    logic              upd;
    logic [DIST_W-1:0] init_val;
    logic              dist_we;
    logic [DIST_W-1:0] dist_wdata;
    logic [63:0]       best_wide;

    always_ff @(posedge clk) begin
        if (cmd.st_wr) begin
            colour_mem[st_addr] <= in_data.edge_colour;
            weight_mem[st_addr] <= in_data.edge_weight;
        end
        colour_rd_reg <= colour_mem[addr_a];
        weight_rd_reg <= weight_mem[addr_a];
    end

    always_ff @(posedge clk) begin
        if (dist_we) begin
            dist_mem[waddr_reg] <= dist_wdata;
        end
        dist_a_reg <= dist_mem[addr_a];
        dist_b_reg <= dist_mem[addr_b];
    end

    always_ff @(posedge clk) begin
        waddr_reg <= cmd.init_rd ? addr_a : addr_b;
        diag_reg  <= cmd.diag;
        if (cmd.ik_load) begin
            ik_reg <= dist_a_reg;
        end
    end

    always_comb begin
        if (diag_reg) begin
            init_val = '0;
        end else if (colour_rd_reg == (LETTER_FIRST + {3'b000, cmd.letter})) begin
            init_val = DIST_W'(weight_rd_reg);
        end else begin
            init_val = DIST_INF;
        end
    end

    // Relaxation through node k: port A holds d[k][j], port B holds d[i][j].
    assign sum = {1'b0, ik_reg[DIST_W-2:0]} + {1'b0, dist_a_reg[DIST_W-2:0]};
    assign upd = stream_v_reg && !dist_a_reg[DIST_W-1] && (sum < dist_b_reg);

    assign dist_we    = init_v_reg || upd;
    assign dist_wdata = init_v_reg ? init_val : sum;

    always_comb begin
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (cmd.best_clear) begin
            best_next     = DIST_INF;
            best_idx_next = '0;
        end else if (cmd.res_cmp && (dist_a_reg < best_reg)) begin
            best_next     = dist_a_reg;
            best_idx_next = cmd.letter;
        end
    end

    assign best_wide = 64'(best_reg[DIST_W-2:0]);

    always_comb begin
        out_data_next = out_data_reg;
        if (cmd.out_load) begin
            out_data_next.path_found = !best_reg[DIST_W-1];
            if (best_reg[DIST_W-1]) begin
                out_data_next.best_letter = '0;
                out_data_next.best_cost   = '0;
            end else begin
                out_data_next.best_letter = best_idx_reg;
                out_data_next.best_cost   = best_wide[COST_W-1:0];
            end
        end
    end

    always_ff @(posedge clk) begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            init_v_reg    <= 1'b0;
            stream_v_reg  <= 1'b0;
            best_reg      <= DIST_INF;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            init_v_reg   <= cmd.init_rd;
            stream_v_reg <= cmd.stream_rd;
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.ik_inf   = dist_a_reg[DIST_W-1];
    assign stat.out_full = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(init_v_reg && stream_v_reg))
        else $error("initialization and relaxation share a distance write");

    a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg)
        else $error("result register overwritten before it was taken");

    a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_cmp && !cmd.best_clear) |=> (best_reg <= $past(best_reg)))
        else $error("best cost increased during a letter comparison");

endmodule

`default_nettype wire

>>> rtl/core/pcsp_ctrl.sv
`default_nettype none

module pcsp_ctrl #(
    parameter int MAX_NODES = pcsp_pkg::DEF_MAX_NODES
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      cfg_wr_en,
    input  wire [5:0]                                cfg_wr_data,
    input  wire                                      in_valid,
    output logic                                     in_ready,
    input  wire                                      in_last,
    input  pcsp_pkg::pcsp_stat_t                     stat,
    output pcsp_pkg::pcsp_cmd_t                      cmd,
    output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]   st_addr,
    output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]   addr_a,
    output logic [$clog2(MAX_NODES*MAX_NODES)-1:0]   addr_b
);
    import pcsp_pkg::*;

    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TOT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int NODE_W = $clog2(MAX_NODES + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT     = 4'd1;
    localparam logic [3:0] S_INIT_END = 4'd2;
    localparam logic [3:0] S_FETCH    = 4'd3;
    localparam logic [3:0] S_WAIT     = 4'd4;
    localparam logic [3:0] S_STREAM   = 4'd5;
    localparam logic [3:0] S_RES_WAIT = 4'd6;
    localparam logic [3:0] S_RES_RD   = 4'd7;
    localparam logic [3:0] S_RES_CMP  = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0]        state_reg,      state_next;
    logic [5:0]        node_count_reg;
    logic [TOT_W-1:0]  load_pos_reg,   load_pos_next;
    logic [4:0]        letter_reg,     letter_next;
    logic [IDX_W-1:0]  i_reg,          i_next;
    logic [IDX_W-1:0]  j_reg,          j_next;
    logic [IDX_W-1:0]  k_reg,          k_next;
    logic [ADDR_W-1:0] lin_reg,        lin_next;
    logic [ADDR_W-1:0] base_i_reg,     base_i_next;
    logic [ADDR_W-1:0] base_k_reg,     base_k_next;

    logic [NODE_W-1:0] n_use;
    logic [IDX_W-1:0]  n_last;
    logic [TOT_W-1:0]  total;
    logic              accept;
    logic              row_end;

    always_comb begin
        if (node_count_reg == '0) begin
            n_use = NODE_W'(1);
        end else if (int'(node_count_reg) > MAX_NODES) begin
            n_use = NODE_W'(MAX_NODES);
        end else begin
            n_use = NODE_W'(node_count_reg);
        end
    end

    assign n_last = IDX_W'(n_use - NODE_W'(1));
    assign total  = TOT_W'(n_use * n_use);
    assign accept = in_valid && in_ready;

    // A row of the k-th pass ends early when it is row k itself or when
    // node i cannot reach node k yet.
    assign row_end = ((state_reg == S_FETCH) && (i_reg == k_reg))
                  || ((state_reg == S_WAIT) && stat.ik_inf)
                  || ((state_reg == S_STREAM) && (j_reg == n_last));

    always_comb begin
        state_next    = state_reg;
        load_pos_next = load_pos_reg;
        letter_next   = letter_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        lin_next      = lin_reg;
        base_i_next   = base_i_reg;
        base_k_next   = base_k_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.letter    = letter_reg;
        st_addr       = load_pos_reg[ADDR_W-1:0];
        addr_a        = lin_reg;
        addr_b        = base_i_reg + ADDR_W'(j_reg);

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    if (load_pos_reg < total) begin
                        cmd.st_wr     = 1'b1;
                        load_pos_next = load_pos_reg + TOT_W'(1);
                    end
                    if (in_last) begin
                        cmd.best_clear = 1'b1;
                        load_pos_next  = '0;
                        letter_next    = '0;
                        i_next         = '0;
                        j_next         = '0;
                        lin_next       = '0;
                        state_next     = S_INIT;
                    end
                end
            end
            S_INIT: begin
                cmd.init_rd = 1'b1;
                cmd.diag    = (i_reg == j_reg);
                lin_next    = lin_reg + ADDR_W'(1);
                if (j_reg == n_last) begin
                    j_next = '0;
                    if (i_reg == n_last) begin
                        state_next = S_INIT_END;
                    end else begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end else begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_INIT_END: begin
                i_next      = '0;
                k_next      = '0;
                base_i_next = '0;
                base_k_next = '0;
                state_next  = S_FETCH;
            end
            S_FETCH: begin
                addr_a = base_i_reg + ADDR_W'(k_reg);
                if (i_reg != k_reg) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                cmd.ik_load = 1'b1;
                j_next      = '0;
                state_next  = S_STREAM;
            end
            S_STREAM: begin
                cmd.stream_rd = 1'b1;
                addr_a        = base_k_reg + ADDR_W'(j_reg);
                j_next        = j_reg + IDX_W'(1);
            end
            S_RES_WAIT: begin
                state_next = S_RES_RD;
            end
            S_RES_RD: begin
                addr_a     = ADDR_W'(n_last);
                state_next = S_RES_CMP;
            end
            S_RES_CMP: begin
                cmd.res_cmp = 1'b1;
                i_next      = '0;
                j_next      = '0;
                lin_next    = '0;
                if (letter_reg == LETTER_LAST) begin
                    state_next = S_OUT;
                end else begin
                    letter_next = letter_reg + 5'd1;
                    state_next  = S_INIT;
                end
            end
            S_OUT: begin
                if (!stat.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (row_end) begin
            if (i_reg == n_last) begin
                i_next      = '0;
                base_i_next = '0;
                if (k_reg == n_last) begin
                    state_next = S_RES_WAIT;
                end else begin
                    k_next      = k_reg + IDX_W'(1);
                    base_k_next = base_k_reg + ADDR_W'(n_use);
                    state_next  = S_FETCH;
                end
            end else begin
                i_next      = i_reg + IDX_W'(1);
                base_i_next = base_i_reg + ADDR_W'(n_use);
                state_next  = S_FETCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_COUNT_RESET;
            load_pos_reg   <= '0;
            letter_reg     <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            lin_reg        <= '0;
            base_i_reg     <= '0;
            base_k_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            letter_reg   <= letter_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            lin_reg      <= lin_next;
            base_i_reg   <= base_i_next;
            base_k_reg   <= base_k_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    a_stream_off_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STREAM) |-> (i_reg != k_reg))
        else $error("relaxation issued on the pivot row");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.st_wr |-> (load_pos_reg < total))
        else $error("matrix entry stored beyond the node count");

    a_last_letter_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RES_CMP) && (letter_reg == LETTER_LAST)) |=> (state_reg == S_OUT))
        else $error("final letter did not lead to the result");

endmodule

`default_nettype wire

>>> rtl/core/per_color_shortest_path.sv
// Per-letter shortest path between node 0 and node n-1.
// Input channel (in_valid/in_ready/in_data): one transaction per matrix entry,
// row-major over n = node_count nodes (0 counts as 1, values above MAX_NODES
// as MAX_NODES). Each accepted entry is stored; entries past n*n are dropped.
// The entry with last_entry set starts the computation and in_ready stays low
// until the result is in the output register. For each letter A..Z the block
// loads the distance matrix, runs the Floyd-Warshall passes over it (one
// relaxation a cycle through the dual-read distance memory), then reads node 0
// to node n-1. Output channel (out_valid/out_ready/out_data): one transaction
// per matrix. A result waiting on a stalled receiver does not block loading of
// the next matrix; only the following result waits for the register to free.
// Configuration: cfg_wr_en writes node_count from cfg_wr_data at once; write it
// only while no matrix is in flight. Reset sets node_count to 32, empties the
// load position and clears out_valid; matrix memories are not cleared.
`default_nettype none

module per_color_shortest_path #(
    parameter int MAX_NODES = pcsp_pkg::DEF_MAX_NODES
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_wr_en,
    input  wire [5:0]            cfg_wr_data,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  pcsp_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output pcsp_pkg::out_item_t  out_data
);
    import pcsp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_NODES * MAX_NODES);

    pcsp_cmd_t         cmd;
    pcsp_stat_t        stat;
    logic [ADDR_W-1:0] st_addr;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;

    pcsp_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_last     (in_data.last_entry),
        .stat        (stat),
        .cmd         (cmd),
        .st_addr     (st_addr),
        .addr_a      (addr_a),
        .addr_b      (addr_b)
    );

    pcsp_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st_addr   (st_addr),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .in_data   (in_data),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
